// ===== rtl/core/olm_pkg.sv =====
package olm_pkg;

  // Loop store geometry: two banks share one memory row.
  localparam int unsigned LoopDepth  = 65536;
  localparam int unsigned RowW       = $clog2(LoopDepth);
  localparam int unsigned LenW       = RowW + 1;
  localparam int unsigned SampleW    = 12;
  localparam int unsigned DropBits   = 4;
  localparam int unsigned LevelW     = 8;
  localparam int unsigned PaddrW     = 3;

  // Reset loop length and the offset-binary code for a zero sample.
  localparam logic [LenW-1:0]   ResetLength = LenW'(10240);
  localparam logic [LevelW-1:0] LevelZero   = LevelW'(128);

  // Register byte addresses.
  localparam logic [PaddrW-1:0] AddrPendingLen = PaddrW'(0);

  // One result as it waits for the output side.
  typedef struct packed {
    logic [LevelW-1:0] dac_level;
    logic              active_bank_now;
    logic              bank_swapped;
  } olm_result_t;

  // Clamp a programmed length into 1..LoopDepth.
  function automatic logic [LenW-1:0] limit_length(input logic [LenW-1:0] len);
    logic [LenW-1:0] res;
    res = len;
    if (len == '0) begin
      res = LenW'(1);
    end else if (len > LenW'(LoopDepth)) begin
      res = LenW'(LoopDepth);
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/olm_out_buf.sv =====
module olm_out_buf
  import olm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  olm_result_t push_data_i,
  input  logic        pop_i,
  output logic        valid_o,
  output olm_result_t head_o,
  output logic [1:0]  count_o
);

  logic [1:0]  cnt_q, cnt_d;
  olm_result_t head_q, head_d;
  olm_result_t tail_q, tail_d;
  logic        pop;

  assign pop = pop_i && (cnt_q != 2'd0);

  // Two-entry buffer: the head register drives the port, the tail catches a stall.
  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    tail_d = tail_q;
    case (cnt_q)
      2'd0: begin
        if (push_i) begin
          head_d = push_data_i;
          cnt_d  = 2'd1;
        end
      end
      2'd1: begin
        if (pop && push_i) begin
          head_d = push_data_i;
        end else if (push_i) begin
          tail_d = push_data_i;
          cnt_d  = 2'd2;
        end else if (pop) begin
          cnt_d  = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_d = tail_q;
          if (push_i) begin
            tail_d = push_data_i;
          end else begin
            cnt_d = 2'd1;
          end
        end
      end
      default: begin
        cnt_d = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = head_q;
  assign count_o = cnt_q;

  // A push into a full buffer would drop a result.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && (cnt_q == 2'd2)) |-> pop_i)
    else $error("output buffer overflow");

  // The count never reaches the unused code.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  // A popped single entry with no push leaves the buffer empty.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cnt_q == 2'd1) && pop_i && !push_i) |=> (cnt_q == 2'd0))
    else $error("output buffer failed to drain");

endmodule

// ===== rtl/core/overdub_loop_mixer_top.sv =====
// Sound-on-sound looper: each request carries one 12-bit converter sample whose top
// eight bits are mixed by halving with the loop sample at the play position, written
// back and returned as an 8-bit DAC level. Both banks live in one 65536 x 16-bit
// synchronous memory, one row per play position. After reset the block clears that
// memory with s_axis_tready low; configuration writes are taken throughout. Each
// sample is then read from memory, mixed and written back; up to two samples
// overlap, so a new sample can be taken before the last is through, with the result
// buffer and the second stage limiting how many are in flight. The loop length
// written at address 0 (bits 16:0 kept) takes effect at the next wrap of the play
// position; 0 counts as 1 and values above 65536 as 65536.
module overdub_loop_mixer_top
  import olm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input stream.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [11:0] adc_sample
  input  logic [0:0]        s_axis_tuser,   // [0] transfer_done
  // Output stream.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [7:0] dac_level
  output logic [1:0]        m_axis_tuser,   // [0] bank_swapped, [1] active_bank_now
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Control state.
  logic [RowW-1:0]   play_idx_q, play_idx_d;
  logic [LenW-1:0]   cur_len_q, cur_len_d;
  logic [LenW-1:0]   pend_len_q;
  logic              bank_q, bank_d;
  logic              xfer_pend_q, xfer_pend_d;

  // Clearing pass.
  logic              clr_busy_q;
  logic [RowW-1:0]   clr_row_q;

  // Second stage: read data arrives, mix, write back.
  logic              s2_vld_q;
  logic [RowW-1:0]   s2_row_q;
  logic              s2_bank_q;
  logic [LevelW-1:0] s2_in_q;
  logic              s2_swap_q;
  logic              s2_abank_q;
  logic              s2_fwd_q;

  // Memory and forwarding.
  logic [2*LevelW-1:0] mem [LoopDepth];
  logic [2*LevelW-1:0] rd_data_q;
  logic [2*LevelW-1:0] wr_data_q;
  logic                mem_we;
  logic [RowW-1:0]     mem_waddr;
  logic [2*LevelW-1:0] mem_wdata;

  logic              in_acc;
  logic              cfg_wr;
  logic              pend_eff;
  logic [LenW-1:0]   next_idx;
  logic              wrap;
  logic              swap;
  logic [LevelW-1:0] in_off;
  logic [2*LevelW-1:0] row_old;
  logic [2*LevelW-1:0] row_new;
  logic [LevelW-1:0] old_off;
  logic [LevelW-1:0] mix_off;
  logic [1:0]        out_cnt;
  olm_result_t       res_in;
  olm_result_t       res_head;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[PaddrW-1:2] == AddrPendingLen[PaddrW-1:2]) ?
                  32'(pend_len_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_len_q <= ResetLength;
    end else if (cfg_wr && (paddr[PaddrW-1:2] == AddrPendingLen[PaddrW-1:2])) begin
      pend_len_q <= pwdata[LenW-1:0];
    end
  end

  // Accept while at most one result is committed to the output side.
  assign s_axis_tready = !clr_busy_q && ((2'(s2_vld_q) + out_cnt) <= 2'd1);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // First stage: advance the play position and settle the bank decision.
  always_comb begin
    pend_eff    = xfer_pend_q && !s_axis_tuser[0];
    next_idx    = LenW'(play_idx_q) + LenW'(1);
    wrap        = (next_idx >= cur_len_q);
    swap        = wrap && !pend_eff;
    play_idx_d  = wrap ? '0 : next_idx[RowW-1:0];
    cur_len_d   = wrap ? limit_length(pend_len_q) : cur_len_q;
    bank_d      = bank_q ^ swap;
    xfer_pend_d = pend_eff || swap;
    in_off      = s_axis_tdata[SampleW-1:DropBits];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      play_idx_q  <= '0;
      cur_len_q   <= limit_length(ResetLength);
      bank_q      <= 1'b0;
      xfer_pend_q <= 1'b0;
      s2_vld_q    <= 1'b0;
    end else begin
      s2_vld_q <= in_acc;
      if (in_acc) begin
        play_idx_q  <= play_idx_d;
        cur_len_q   <= cur_len_d;
        bank_q      <= bank_d;
        xfer_pend_q <= xfer_pend_d;
      end
    end
  end

  // Second-stage payload; the forward flag marks a read that raced a write to its row.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s2_row_q   <= play_idx_q;
      s2_bank_q  <= bank_q;
      s2_in_q    <= in_off;
      s2_swap_q  <= swap;
      s2_abank_q <= bank_d;
      s2_fwd_q   <= s2_vld_q && (s2_row_q == play_idx_q);
    end
  end

  // Mix in offset binary: halve both levels and add.
  always_comb begin
    row_old = s2_fwd_q ? wr_data_q : rd_data_q;
    old_off = s2_bank_q ? row_old[2*LevelW-1:LevelW] : row_old[LevelW-1:0];
    mix_off = (old_off >> 1) + (s2_in_q >> 1);
    row_new = s2_bank_q ? {mix_off, row_old[LevelW-1:0]}
                        : {row_old[2*LevelW-1:LevelW], mix_off};
  end

  // Clearing pass after reset, one row per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_row_q  <= '0;
    end else if (clr_busy_q) begin
      clr_row_q <= clr_row_q + RowW'(1);
      if (clr_row_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign mem_we    = clr_busy_q || s2_vld_q;
  assign mem_waddr = clr_busy_q ? clr_row_q : s2_row_q;
  assign mem_wdata = clr_busy_q ? {LevelZero, LevelZero} : row_new;

  // Loop store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[play_idx_q];
  end

  // Keep the last written row for a read issued in the same cycle.
  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      wr_data_q <= row_new;
    end
  end

  // Results leave through a two-entry buffer.
  assign res_in.dac_level       = mix_off;
  assign res_in.active_bank_now = s2_abank_q;
  assign res_in.bank_swapped    = s2_swap_q;

  olm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_vld_q),
    .push_data_i (res_in),
    .pop_i       (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .head_o      (res_head),
    .count_o     (out_cnt)
  );

  assign m_axis_tdata = res_head.dac_level;
  assign m_axis_tuser = {res_head.active_bank_now, res_head.bank_swapped};

  // The play position always lies inside the current loop.
  a_idx_in_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LenW'(play_idx_q) < cur_len_q)
    else $error("play position outside loop");

  // A bank swap leaves a transfer request pending.
  a_swap_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && swap) |=> (xfer_pend_q && (bank_q != $past(bank_q))))
    else $error("bank swap without transfer request");

  // No sample is taken during the clearing pass.
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_acc && !s2_vld_q)
    else $error("sample accepted while clearing");

  // A swap always lands on the start of the loop.
  a_swap_at_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && swap) |=> (play_idx_q == '0))
    else $error("bank swap away from the wrap");

endmodule
